// ===== hdl/esub_pkg.sv =====
// esub_pkg: shared constants, codes and types of the event subscriber table
// no dependencies; used by esub_out, event_subscriber_table and the bench
`default_nettype none

package esub_pkg;

    // default sizes of the table
    localparam int EVENTS_DEF  = 32;
    localparam int MODULES_DEF = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int LISTED_W = 4;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PLACE  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVENT_BAD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MODULE_BAD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,  // waiting for a word
        S_CNT,   // count read back, decide
        S_RD,    // read list entry for search
        S_CHK,   // compare list entry
        S_SHR,   // read next entry for compaction
        S_SHW,   // write entry one slot down
        S_QRD,   // read list entry for query
        S_QEM    // emit query entry
    } t_state;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LISTED_W-1:0] listed_module;
        logic                entry_valid;
        logic [COUNT_W-1:0]  list_count;
        logic                last;
    } t_word;

endpackage

`default_nettype wire

// ===== hdl/esub_ram.sv =====
// esub_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module esub_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/esub_out.sv =====
// esub_out: output register for result words, parts the sequencer from the consumer
// depends on esub_pkg
`default_nettype none

module esub_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire esub_pkg::t_word i_word,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output esub_pkg::t_word      o_word
);

    logic            r_valid;
    logic            n_valid;
    esub_pkg::t_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_push || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== hdl/event_subscriber_table.sv =====
// event_subscriber_table: ordered subscriber list per event, place / remove / query
// depends on esub_pkg, esub_ram, esub_out
// sequence: the count is decided in the cycle after accept, where a one-word result is
//   pushed into the output register once it has room; each list entry searched, shifted
//   or queried takes a read state and then a check, write or emit state
// one word at a time: a new word is taken only in the idle state, after the last result
//   word of the previous one is pushed; a consumer holding off results stalls the sequencer
// reset clears the per-event count valid bits; list memory is not cleared
`default_nettype none

module event_subscriber_table #(
    parameter int EVENTS  = esub_pkg::EVENTS_DEF,
    parameter int MODULES = esub_pkg::MODULES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [esub_pkg::OP_W-1:0]     i_operation,
    input  wire logic [esub_pkg::ID_W-1:0]     i_event_id,
    input  wire logic [esub_pkg::ID_W-1:0]     i_module_id,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [esub_pkg::STATUS_W-1:0]      o_status,
    output logic [esub_pkg::LISTED_W-1:0]      o_listed_module,
    output logic                               o_entry_valid,
    output logic [esub_pkg::COUNT_W-1:0]       o_list_count,
    output logic                               o_last
);

    // derived sizes
    localparam int EV_W    = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int ENTRY_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int CNT_W   = $clog2(MODULES + 1);
    localparam int DEPTH   = EVENTS * MODULES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // latched input word
    logic [esub_pkg::OP_W-1:0] r_op;
    logic [esub_pkg::ID_W-1:0] r_ev;
    logic [esub_pkg::ID_W-1:0] r_mod;
    logic [ADDR_W-1:0]         r_base;   // first slot of the addressed list

    // sequencer state
    esub_pkg::t_state r_state;
    esub_pkg::t_state n_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] r_n;               // list count captured at decision time
    logic [CNT_W-1:0] n_n;

    // count valid bits, one per event, cleared by reset
    logic [EVENTS-1:0] r_cnt_vld;

    // memory ports
    logic              w_st_re;
    logic [ADDR_W-1:0] w_st_raddr;
    logic              w_st_we;
    logic [ADDR_W-1:0] w_st_waddr;
    logic [ENTRY_W-1:0] w_st_wdata;
    logic [ENTRY_W-1:0] w_st_q;
    logic              w_cnt_re;
    logic              w_cnt_we;
    logic [CNT_W-1:0]  w_cnt_wdata;
    logic [CNT_W-1:0]  w_cnt_q;

    // decision signals
    logic              w_accept;
    logic              w_ev_ok;
    logic              w_mod_ok;
    logic [CNT_W-1:0]  w_n;
    logic              w_hit;
    logic              w_last_idx;
    logic              w_shift_done;
    logic              w_free;
    logic              w_go;

    // action of the current state, before gating by the output register
    logic              w_emit;
    esub_pkg::t_word   w_word;
    logic              w_rd;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic              w_cw;
    logic [CNT_W-1:0]  w_cw_data;
    logic              w_step;
    esub_pkg::t_state  w_goto;

    esub_pkg::t_word   w_out_word;

    assign o_ready  = (r_state == esub_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_ev_ok    = ({1'b0, r_ev} < 9'(EVENTS));
    assign w_mod_ok   = ({1'b0, r_mod} < 9'(MODULES));
    // a list never holds more than MODULES entries, so no clamp is needed
    assign w_n        = (w_ev_ok && r_cnt_vld[r_ev[EV_W-1:0]]) ? w_cnt_q : '0;
    assign w_hit      = (esub_pkg::ID_W'(w_st_q) == r_mod);
    assign w_last_idx = (CNT_W'(r_idx + 1'b1) == r_n);
    assign w_shift_done = (CNT_W'(r_idx + 2'd2) == r_n);
    assign w_go       = !w_emit || w_free;

    // per-state action
    always_comb begin
        w_emit    = 1'b0;
        w_word    = '0;
        w_rd      = 1'b0;
        w_rd_addr = r_base + ADDR_W'(r_idx);
        w_wr      = 1'b0;
        w_wr_addr = r_base + ADDR_W'(r_idx);
        w_wr_data = w_st_q;
        w_cw      = 1'b0;
        w_cw_data = r_n;
        w_step    = 1'b0;
        w_goto    = r_state;
        unique case (r_state)
            esub_pkg::S_IDLE: begin
                w_goto = esub_pkg::S_IDLE;
            end
            esub_pkg::S_CNT: begin
                w_word.last       = 1'b1;
                w_word.list_count = esub_pkg::COUNT_W'(w_n);
                if (r_op != esub_pkg::OP_PLACE && r_op != esub_pkg::OP_REMOVE
                        && r_op != esub_pkg::OP_QUERY) begin
                    // unused code: no operation
                    w_emit            = 1'b1;
                    w_word.list_count = '0;
                end else if (!w_ev_ok) begin
                    w_emit            = 1'b1;
                    w_word.status     = esub_pkg::ST_EVENT_BAD;
                    w_word.list_count = '0;
                end else if (r_op == esub_pkg::OP_PLACE) begin
                    if (!w_mod_ok) begin
                        w_emit        = 1'b1;
                        w_word.status = esub_pkg::ST_MODULE_BAD;
                    end else if (w_n >= CNT_W'(MODULES)) begin
                        w_emit        = 1'b1;
                        w_word.status = esub_pkg::ST_FULL;
                    end else if (w_n == '0) begin
                        // empty list: append at once
                        w_emit            = 1'b1;
                        w_wr              = 1'b1;
                        w_wr_addr         = r_base;
                        w_wr_data         = ENTRY_W'(r_mod);
                        w_cw              = 1'b1;
                        w_cw_data         = CNT_W'(1);
                        w_word.list_count = esub_pkg::COUNT_W'(1);
                    end else begin
                        w_goto = esub_pkg::S_RD;
                    end
                end else if (w_n == '0) begin
                    // remove or query of an empty list
                    w_emit = 1'b1;
                end else if (r_op == esub_pkg::OP_REMOVE) begin
                    w_goto = esub_pkg::S_RD;
                end else begin
                    w_goto = esub_pkg::S_QRD;
                end
            end
            esub_pkg::S_RD: begin
                w_rd   = 1'b1;
                w_goto = esub_pkg::S_CHK;
            end
            esub_pkg::S_CHK: begin
                w_word.last       = 1'b1;
                w_word.list_count = esub_pkg::COUNT_W'(r_n);
                if (r_op == esub_pkg::OP_PLACE) begin
                    if (w_hit) begin
                        w_emit        = 1'b1;
                        w_word.status = esub_pkg::ST_ALREADY;
                    end else if (w_last_idx) begin
                        // searched the whole list: append at the tail
                        w_emit            = 1'b1;
                        w_wr              = 1'b1;
                        w_wr_addr         = r_base + ADDR_W'(r_n);
                        w_wr_data         = ENTRY_W'(r_mod);
                        w_cw              = 1'b1;
                        w_cw_data         = CNT_W'(r_n + 1'b1);
                        w_word.list_count = esub_pkg::COUNT_W'(r_n + 1'b1);
                    end else begin
                        w_step = 1'b1;
                        w_goto = esub_pkg::S_RD;
                    end
                end else begin
                    if (w_hit && w_last_idx) begin
                        // tail entry removed, nothing to shift
                        w_emit            = 1'b1;
                        w_cw              = 1'b1;
                        w_cw_data         = CNT_W'(r_n - 1'b1);
                        w_word.list_count = esub_pkg::COUNT_W'(r_n - 1'b1);
                    end else if (w_hit) begin
                        w_goto = esub_pkg::S_SHR;
                    end else if (w_last_idx) begin
                        w_emit = 1'b1;
                    end else begin
                        w_step = 1'b1;
                        w_goto = esub_pkg::S_RD;
                    end
                end
            end
            esub_pkg::S_SHR: begin
                w_rd      = 1'b1;
                w_rd_addr = r_base + ADDR_W'(r_idx + 1'b1);
                w_goto    = esub_pkg::S_SHW;
            end
            esub_pkg::S_SHW: begin
                w_wr = 1'b1;
                if (w_shift_done) begin
                    w_emit            = 1'b1;
                    w_cw              = 1'b1;
                    w_cw_data         = CNT_W'(r_n - 1'b1);
                    w_word.last       = 1'b1;
                    w_word.list_count = esub_pkg::COUNT_W'(r_n - 1'b1);
                end else begin
                    w_step = 1'b1;
                    w_goto = esub_pkg::S_SHR;
                end
            end
            esub_pkg::S_QRD: begin
                w_rd   = 1'b1;
                w_goto = esub_pkg::S_QEM;
            end
            esub_pkg::S_QEM: begin
                w_word.listed_module = esub_pkg::LISTED_W'(w_st_q);
                w_word.entry_valid   = 1'b1;
                w_word.list_count    = esub_pkg::COUNT_W'(r_n);
                w_word.last          = w_last_idx;
                if (w_last_idx) begin
                    w_emit = 1'b1;
                end else begin
                    w_emit = 1'b1;
                    w_step = 1'b1;
                    w_goto = esub_pkg::S_QRD;
                end
            end
            default: begin
                w_goto = esub_pkg::S_IDLE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        if (r_state == esub_pkg::S_IDLE) begin
            if (w_accept) begin
                n_state = esub_pkg::S_CNT;
            end
        end else if (r_state == esub_pkg::S_CNT) begin
            n_idx = '0;
            n_n   = w_n;
            if (w_go) begin
                n_state = w_emit ? esub_pkg::S_IDLE : w_goto;
            end
        end else if (w_go) begin
            // a query entry that is not the last keeps going after its emit
            if (w_emit && !w_step) begin
                n_state = esub_pkg::S_IDLE;
            end else begin
                n_state = w_goto;
            end
            if (w_step) begin
                n_idx = CNT_W'(r_idx + 1'b1);
            end
        end
    end

    // outputs: memory controls; writes, like the result push, are gated by room in the output register
    always_comb begin
        w_cnt_re    = w_accept;
        w_cnt_we    = w_cw && w_go;
        w_cnt_wdata = w_cw_data;
        w_st_re     = w_rd;
        w_st_raddr  = w_rd_addr;
        w_st_we     = w_wr && w_go;
        w_st_waddr  = w_wr_addr;
        w_st_wdata  = w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= esub_pkg::S_IDLE;
            r_cnt_vld <= '0;
        end else begin
            r_state <= n_state;
            if (w_cnt_we) begin
                r_cnt_vld[r_ev[EV_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_n   <= n_n;
        if (w_accept) begin
            r_op   <= i_operation;
            r_ev   <= i_event_id;
            r_mod  <= i_module_id;
            r_base <= ADDR_W'(i_event_id * MODULES);
        end
    end

    // list entries, MODULES slots per event
    esub_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (w_st_re),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_q)
    );

    // list counts, meaningful only where the valid bit is set
    esub_ram #(
        .WIDTH (CNT_W),
        .DEPTH (EVENTS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_ev[EV_W-1:0]),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_cnt_re),
        .i_raddr (i_event_id[EV_W-1:0]),
        .o_rdata (w_cnt_q)
    );

    // result word register
    esub_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit && w_free),
        .i_word  (w_word),
        .o_free  (w_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (w_out_word)
    );

    assign o_status        = w_out_word.status;
    assign o_listed_module = w_out_word.listed_module;
    assign o_entry_valid   = w_out_word.entry_valid;
    assign o_list_count    = w_out_word.list_count;
    assign o_last          = w_out_word.last;

    // an accepted word always moves the sequencer on to the count decision
    a_accept_to_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == esub_pkg::S_CNT))
        else $error("accepted word did not start a count read");

    // counts never grow beyond the list capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_we |-> (w_cnt_wdata <= CNT_W'(MODULES)))
        else $error("count write exceeds list capacity");

    // list memory is written only by place or compaction
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st_we |-> (r_state == esub_pkg::S_CNT || r_state == esub_pkg::S_CHK
                     || r_state == esub_pkg::S_SHW))
        else $error("list write outside place or remove");

    // a real list entry is never reported with an empty count
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_valid) |-> (o_list_count != '0))
        else $error("valid entry with zero count");

    // no result is pushed while the sequencer is idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esub_pkg::S_IDLE) |-> !w_emit)
        else $error("result pushed while idle");

endmodule

`default_nettype wire

// ===== tb/event_subscriber_table_test.sv =====
// event_subscriber_table_test: self-checking bench for the per-event subscriber lists
// runs directed and random place / remove / query words and predicts every result word
// depends on esub_pkg and event_subscriber_table
module event_subscriber_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esub_pkg::*;

    localparam int NUM_EVENTS  = EVENTS_DEF;
    localparam int NUM_MODULES = MODULES_DEF;
    localparam int RAND_WORDS  = 200;
    localparam int TAIL_CYCLES = 100;     // idle time after the drain, for a stray result word to show
    localparam int CYCLE_LIMIT = 400000;  // watchdog limit for a hung run

    // the one operation code that the block treats as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam t_word NO_WORD = '0;

    // one row of the directed table; typed rows carry their single result word
    typedef struct {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] ev;
        logic [ID_W-1:0] mod;
        bit              typed;
        t_word           word;
    } t_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [OP_W-1:0]     i_operation = '0;
    logic [ID_W-1:0]     i_event_id  = '0;
    logic [ID_W-1:0]     i_module_id = '0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [LISTED_W-1:0] o_listed_module;
    logic                o_entry_valid;
    logic [COUNT_W-1:0]  o_list_count;
    logic                o_last;

    // sideband that travels with the word on the input channel
    bit    use_typed  = 1'b0;
    t_word typed_word = '0;
    bit    idle_on    = 1'b1;

    // shadow copy of the subscriber table
    logic [LISTED_W-1:0] shadow_lists [NUM_EVENTS][NUM_MODULES];
    int                  shadow_counts [NUM_EVENTS];
    t_word               owed_replies [$];

    int mismatches   = 0;
    int words_in     = 0;
    int words_out    = 0;
    int full_rejects = 0;
    int cycle_count  = 0;
    int stall_left   = 0;

    event_subscriber_table #(
        .EVENTS  (NUM_EVENTS),
        .MODULES (NUM_MODULES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_event_id      (i_event_id),
        .i_module_id     (i_module_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_listed_module (o_listed_module),
        .o_entry_valid   (o_entry_valid),
        .o_list_count    (o_list_count),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // single-result word with last set, for the typed rows
    function automatic t_word reply(input logic [STATUS_W-1:0] status, input int count);
        t_word w;
        w            = '0;
        w.status     = status;
        w.list_count = COUNT_W'(count);
        w.last       = 1'b1;
        return w;
    endfunction

    function automatic t_row row(input logic [OP_W-1:0] op, input int ev, input int mod,
                                 input bit typed, input t_word word);
        t_row r;
        r.op    = op;
        r.ev    = ID_W'(ev);
        r.mod   = ID_W'(mod);
        r.typed = typed;
        r.word  = word;
        return r;
    endfunction

    // applies one accepted word to the shadow table and queues the result words it owes
    function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                           input logic [ID_W-1:0] ev,
                                           input logic [ID_W-1:0] mod,
                                           input bit typed, input t_word word);
        t_word made [$];
        t_word w;
        int    n;
        int    hit;
        w      = '0;
        w.last = 1'b1;
        hit    = -1;
        if (op != OP_PLACE && op != OP_REMOVE && op != OP_QUERY) begin
            // unused code: plain ok, nothing touched, event not even looked at
            made.push_back(w);
        end else if (ev >= NUM_EVENTS) begin
            w.status = ST_EVENT_BAD;
            made.push_back(w);
        end else begin
            n = shadow_counts[ev];
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && {4'd0, shadow_lists[ev][i]} == mod) begin
                    hit = i;
                end
            end
            case (op)
                OP_PLACE: begin
                    // check order matters: module, then room, then duplicate
                    if (mod >= NUM_MODULES) begin
                        w.status = ST_MODULE_BAD;
                    end else if (n >= NUM_MODULES) begin
                        w.status = ST_FULL;
                    end else if (hit >= 0) begin
                        w.status = ST_ALREADY;
                    end else begin
                        shadow_lists[ev][n] = LISTED_W'(mod);
                        n++;
                        shadow_counts[ev] = n;
                    end
                    w.list_count = COUNT_W'(n);
                    made.push_back(w);
                end
                OP_REMOVE: begin
                    // unlisted or out-of-range module is a silent ok
                    if (hit >= 0) begin
                        for (int j = hit; j + 1 < n; j++) begin
                            shadow_lists[ev][j] = shadow_lists[ev][j + 1];
                        end
                        n--;
                        shadow_counts[ev] = n;
                    end
                    w.list_count = COUNT_W'(n);
                    made.push_back(w);
                end
                default: begin
                    if (n == 0) begin
                        made.push_back(w);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            w.listed_module = shadow_lists[ev][i];
                            w.entry_valid   = 1'b1;
                            w.list_count    = COUNT_W'(n);
                            w.last          = (i + 1 == n);
                            made.push_back(w);
                        end
                    end
                end
            endcase
        end
        if (typed) begin
            owed_replies.push_back(word);
        end else begin
            foreach (made[i]) owed_replies.push_back(made[i]);
        end
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_reply();
        t_word want;
        if (owed_replies.size() == 0) begin
            $error("result word with none outstanding: status %0d module %0d count %0d",
                   o_status, o_listed_module, o_list_count);
            mismatches++;
        end else begin
            want = owed_replies.pop_front();
            compare_field("status", want.status, o_status);
            compare_field("listed_module", want.listed_module, o_listed_module);
            compare_field("entry_valid", want.entry_valid, o_entry_valid);
            compare_field("list_count", want.list_count, o_list_count);
            compare_field("last", want.last, o_last);
        end
        if (o_status == ST_FULL) full_rejects++;
        words_out++;
    endfunction

    // both channels are sampled here, in one process, so a word accepted and a result
    // taken at the same edge are always handled in the same order
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            apply_table_op(i_operation, i_event_id, i_module_id, use_typed, typed_word);
            words_in++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            check_reply();
        end
    end

    // result side back-pressure: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offers one word and returns at the edge where it is taken; valid stays high so
    // the next word can follow back to back
    task automatic send_word(input logic [OP_W-1:0] op, input int ev, input int mod,
                             input bit typed, input t_word word);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_event_id  <= ID_W'(ev);
        i_module_id <= ID_W'(mod);
        use_typed   <= typed;
        typed_word  <= word;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // event drawn mostly from a small hot set so lists fill up, sometimes anything
    function automatic int pick_event(input int hot [3]);
        if ($urandom_range(0, 19) < 17) return hot[$urandom_range(0, 2)];
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_module();
        if ($urandom_range(0, 19) < 17) return $urandom_range(0, NUM_MODULES - 1);
        return $urandom_range(0, 255);
    endfunction

    initial begin
        t_row plan [25];
        int   hot [3];
        int   perm [NUM_MODULES];
        int   done_rand;
        int   ev;
        int   k;
        int   tmp;
        int   sel;
        logic [OP_W-1:0] op;

        for (int e = 0; e < NUM_EVENTS; e++) shadow_counts[e] = 0;

        // directed words: extremes, error codes, the odd remove cases and the shifts
        plan = '{
            row(OP_QUERY,  0,   0,   1, reply(ST_OK, 0)),          // empty after reset
            row(OP_UNUSED, 0,   0,   1, reply(ST_OK, 0)),          // unused code
            row(OP_UNUSED, 255, 255, 1, reply(ST_OK, 0)),          // unused beats bad event
            row(OP_PLACE,  32,  0,   1, reply(ST_EVENT_BAD, 0)),   // first bad event
            row(OP_QUERY,  255, 0,   1, reply(ST_EVENT_BAD, 0)),
            row(OP_REMOVE, 128, 3,   1, reply(ST_EVENT_BAD, 0)),
            row(OP_PLACE,  0,   16,  1, reply(ST_MODULE_BAD, 0)),  // first bad module
            row(OP_PLACE,  0,   255, 1, reply(ST_MODULE_BAD, 0)),
            row(OP_PLACE,  0,   0,   1, reply(ST_OK, 1)),
            row(OP_PLACE,  0,   15,  1, reply(ST_OK, 2)),
            row(OP_PLACE,  0,   0,   1, reply(ST_ALREADY, 2)),     // duplicate
            row(OP_PLACE,  31,  7,   1, reply(ST_OK, 1)),          // last event
            row(OP_QUERY,  0,   0,   0, NO_WORD),
            row(OP_REMOVE, 0,   200, 1, reply(ST_OK, 2)),          // remove out of range
            row(OP_REMOVE, 0,   9,   1, reply(ST_OK, 2)),          // remove not listed
            row(OP_PLACE,  0,   9,   0, NO_WORD),
            row(OP_REMOVE, 0,   0,   0, NO_WORD),                  // head out, rest shift
            row(OP_QUERY,  0,   85,  0, NO_WORD),
            row(OP_REMOVE, 0,   9,   0, NO_WORD),                  // tail out
            row(OP_REMOVE, 0,   15,  0, NO_WORD),                  // list back to empty
            row(OP_QUERY,  0,   170, 1, reply(ST_OK, 0)),
            row(OP_QUERY,  31,  0,   0, NO_WORD),
            row(OP_REMOVE, 31,  7,   0, NO_WORD),
            row(OP_PLACE,  31,  170, 1, reply(ST_MODULE_BAD, 0)),
            row(OP_PLACE,  85,  85,  1, reply(ST_EVENT_BAD, 0))
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            send_word(plan[r].op, plan[r].ev, plan[r].mod, plan[r].typed, plan[r].word);
        end

        // random part: fill runs that push a hot list to full, mixed with loose words
        hot[0] = 0;
        hot[1] = NUM_EVENTS - 1;
        hot[2] = $urandom_range(1, NUM_EVENTS - 2);
        done_rand = 0;
        while (done_rand < RAND_WORDS) begin
            // idling in stretches, switched off for good once no more than forty words remain
            idle_on <= (done_rand < RAND_WORDS - 40) && ((done_rand / 30) % 3 != 2);
            if ($urandom_range(0, 3) == 0) begin
                ev = hot[$urandom_range(0, 2)];
                for (int j = 0; j < NUM_MODULES; j++) perm[j] = j;
                for (int j = NUM_MODULES - 1; j > 0; j--) begin
                    sel       = $urandom_range(0, j);
                    tmp       = perm[j];
                    perm[j]   = perm[sel];
                    perm[sel] = tmp;
                end
                // a few past the list size so full and duplicate both show up
                k = $urandom_range(NUM_MODULES - 6, NUM_MODULES + 2);
                for (int j = 0; j < k; j++) begin
                    send_word(OP_PLACE, ev,
                              (j < NUM_MODULES) ? perm[j] : $urandom_range(0, NUM_MODULES - 1),
                              0, NO_WORD);
                end
                send_word(OP_QUERY, ev, $urandom_range(0, 255), 0, NO_WORD);
                done_rand += k + 1;
            end else begin
                sel = $urandom_range(0, 19);
                if (sel < 8) op = OP_PLACE;
                else if (sel < 14) op = OP_REMOVE;
                else if (sel < 19) op = OP_QUERY;
                else op = OP_UNUSED;
                send_word(op, pick_event(hot), pick_module(), 0, NO_WORD);
                done_rand++;
            end
        end
        i_valid <= 1'b0;

        // drain, then give the block time to show any stray result word
        while (owed_replies.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d words in and %0d result words checked", words_in, words_out);
        $display("lists filled to the brim and rejected %0d places", full_rejects);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
